@@ rtl/core/oriented_box_overlap_test_defines.svh @@
// Assertion macros shared by the overlap test RTL.
`ifndef ORIENTED_BOX_OVERLAP_TEST_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define OBBT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define OBBT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/obbt_pkg.sv @@
package obbt_pkg;

  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_FRAC_BITS  = 8;
  localparam int FIELD_W        = 48;
  localparam int NUM_AXES       = 15;
  localparam int CELL_STAGES    = 6;

  typedef enum logic [2:0] {
    REG_OWN_CENTER  = 3'd0,
    REG_OWN_AXIS_X  = 3'd1,
    REG_OWN_AXIS_Y  = 3'd2,
    REG_OWN_AXIS_Z  = 3'd3,
    REG_OWN_EXTENTS = 3'd4
  } reg_idx_t;

  // Control handed from one cell to the next.
  typedef struct packed {
    logic valid;
    logic sep;
  } obbt_flag_t;

  // Axis pairs whose cross product gives the face normals: xy, yz, xz.
  function automatic int face_first(input int f);
    case (f)
      1:       return 1;
      default: return 0;
    endcase
  endfunction

  function automatic int face_second(input int f);
    case (f)
      0:       return 1;
      default: return 2;
    endcase
  endfunction

endpackage

@@ rtl/core/oriented_box_overlap_test.sv @@
// One cell per candidate axis, 15 axes in a row; the result is taken from the last cell.
// Throughput: one item per cycle; a new item enters each cycle the chain advances.
// The chain stalls as a whole only while a finished result waits at the output.
// Reset (rst, synchronous, active high) clears all valid flags and the five box
// registers; items in flight are dropped.
`include "oriented_box_overlap_test_defines.svh"

module oriented_box_overlap_test #(
  parameter int COORD_BITS = obbt_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = obbt_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_addr,
  input  logic [obbt_pkg::FIELD_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [obbt_pkg::FIELD_W-1:0] other_center,
  input  logic [obbt_pkg::FIELD_W-1:0] other_axis_x,
  input  logic [obbt_pkg::FIELD_W-1:0] other_axis_y,
  input  logic [obbt_pkg::FIELD_W-1:0] other_axis_z,
  input  logic [obbt_pkg::FIELD_W-1:0] other_extents,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         overlap
);

  // Each stored or incoming vector holds three components of COORD_BITS,
  // x in the low bits. A box is five such words: center, three axes, extents.
  localparam int VW = 3 * COORD_BITS;
  localparam int BW = 5 * VW;
  localparam int NA = obbt_pkg::NUM_AXES;

  logic [VW-1:0] own_center;
  logic [VW-1:0] own_axis_x;
  logic [VW-1:0] own_axis_y;
  logic [VW-1:0] own_axis_z;
  logic [VW-1:0] own_extents;

  logic [BW-1:0] own_box;
  logic [BW-1:0] oth_box;

  obbt_pkg::obbt_flag_t flag [NA+1];
  logic [BW-1:0]        oth  [NA+1];

  logic adv;

  // Configuration writes land directly; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_center  <= '0;
      own_axis_x  <= '0;
      own_axis_y  <= '0;
      own_axis_z  <= '0;
      own_extents <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        obbt_pkg::REG_OWN_CENTER:  own_center  <= VW'(cfg_data);
        obbt_pkg::REG_OWN_AXIS_X:  own_axis_x  <= VW'(cfg_data);
        obbt_pkg::REG_OWN_AXIS_Y:  own_axis_y  <= VW'(cfg_data);
        obbt_pkg::REG_OWN_AXIS_Z:  own_axis_z  <= VW'(cfg_data);
        obbt_pkg::REG_OWN_EXTENTS: own_extents <= VW'(cfg_data);
        default: ;
      endcase
    end
  end

  assign own_box = {own_extents, own_axis_z, own_axis_y, own_axis_x, own_center};
  assign oth_box = {VW'(other_extents), VW'(other_axis_z), VW'(other_axis_y),
                    VW'(other_axis_x), VW'(other_center)};

  // The last stage of the last cell is the output register. The whole chain
  // moves whenever that register is empty or being taken.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign flag[0].valid = in_valid;
  assign flag[0].sep   = 1'b0;
  assign oth[0]        = oth_box;

  // One cell per candidate axis; each folds its verdict into the running
  // separation flag that travels with the item.
  for (genvar a = 0; a < NA; a++) begin : g_cell
    obbt_cell #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .AXIS      (a)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .flag_in (flag[a]),
      .own_box (own_box),
      .oth_in  (oth[a]),
      .flag_out(flag[a+1]),
      .oth_out (oth[a+1])
    );
  end

  assign out_valid = flag[NA].valid;
  assign overlap   = !flag[NA].sep;

  `OBBT_ASSERT_NOW(a_stall_only_when_full, !in_ready, out_valid, "stall without pending result")
  `OBBT_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid, "result dropped")
  `OBBT_ASSERT_NEXT(a_result_stable, out_valid && !out_ready, $stable(overlap),
                    "result changed while stalled")

endmodule

@@ rtl/core/obbt_cell.sv @@
module obbt_cell #(
  parameter int COORD_BITS = obbt_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = obbt_pkg::DEF_FRAC_BITS,
  parameter int AXIS       = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  obbt_pkg::obbt_flag_t     flag_in,
  input  logic [15*COORD_BITS-1:0] own_box,
  input  logic [15*COORD_BITS-1:0] oth_in,
  output obbt_pkg::obbt_flag_t     flag_out,
  output logic [15*COORD_BITS-1:0] oth_out
);

  localparam int C    = COORD_BITS;
  localparam int BW   = 15 * C;
  localparam int LW   = 2 * C + 1;
  localparam int PW   = C + LW;
  localparam int DW   = PW + 2;
  localparam int DDW  = C + LW + 3;
  localparam int EW   = C + DW;
  localparam int LHW  = DDW + FRAC_BITS;
  localparam int CW   = LHW + EW + 3;
  localparam int NS   = obbt_pkg::CELL_STAGES;
  // Axis kinds: own face normal, other face normal, own edge cross other edge.
  localparam int KIND = (AXIS < 3) ? 0 : ((AXIS < 6) ? 1 : 2);
  localparam int UI   = (KIND == 0) ? obbt_pkg::face_first(AXIS) :
                        (KIND == 1) ? obbt_pkg::face_first(AXIS - 3) : (AXIS - 6) / 3;
  localparam int VI   = (KIND == 0) ? obbt_pkg::face_second(AXIS) :
                        (KIND == 1) ? obbt_pkg::face_second(AXIS - 3) : (AXIS - 6) % 3;
  localparam bit USRC = (KIND == 1);
  localparam bit VSRC = (KIND != 0);

  obbt_pkg::obbt_flag_t    flg [NS];
  logic [BW-1:0]           box [NS];

  logic signed [C-1:0]     u [3];
  logic signed [C-1:0]     v [3];
  logic                    ok;

  logic signed [2*C-1:0]   pa [3];
  logic signed [2*C-1:0]   pb [3];
  logic signed [LW-1:0]    l [3];
  logic signed [C:0]       d [3];
  logic signed [PW-1:0]    po [3][3];
  logic signed [PW-1:0]    pq [3][3];
  logic signed [C+LW:0]    pd [3];
  logic [DW-1:0]           mo [3];
  logic [DW-1:0]           mq [3];
  logic [DDW-1:0]          md;
  logic [EW-1:0]           ro [3];
  logic [EW-1:0]           rq [3];
  logic [LHW-1:0]          lhs;

  logic signed [DW-1:0]    so [3];
  logic signed [DW-1:0]    sq [3];
  logic signed [DDW-1:0]   sd;
  logic [CW-1:0]           rsum;
  logic                    sep_hit;

  // A zero extent on either defining side makes the axis degenerate; it is zeroed.
  always_comb begin
    logic [BW-1:0] ub;
    logic [BW-1:0] vb;
    ub = USRC ? oth_in : own_box;
    vb = VSRC ? oth_in : own_box;
    for (int k = 0; k < 3; k++) begin
      u[k] = $signed(ub[((1 + UI) * 3 + k) * C +: C]);
      v[k] = $signed(vb[((1 + VI) * 3 + k) * C +: C]);
    end
    ok = (ub[(12 + UI) * C +: C] != '0) && (vb[(12 + VI) * C +: C] != '0);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d[k] = (C + 1)'($signed(box[1][k * C +: C])) -
             (C + 1)'($signed(own_box[k * C +: C]));
    end
    for (int i = 0; i < 3; i++) begin
      so[i] = DW'(po[i][0]) + DW'(po[i][1]) + DW'(po[i][2]);
      sq[i] = DW'(pq[i][0]) + DW'(pq[i][1]) + DW'(pq[i][2]);
    end
    sd      = DDW'(pd[0]) + DDW'(pd[1]) + DDW'(pd[2]);
    rsum    = CW'(ro[0]) + CW'(ro[1]) + CW'(ro[2]) +
              CW'(rq[0]) + CW'(rq[1]) + CW'(rq[2]);
    sep_hit = CW'(lhs) > rsum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NS; s++) begin
        flg[s] <= '0;
      end
    end else if (adv) begin
      flg[0] <= flag_in;
      for (int s = 1; s < NS - 1; s++) begin
        flg[s] <= flg[s-1];
      end
      flg[NS-1].valid <= flg[NS-2].valid;
      flg[NS-1].sep   <= flg[NS-2].sep | sep_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box[0] <= oth_in;
      for (int s = 1; s < NS; s++) begin
        box[s] <= box[s-1];
      end
      // Cross product halves, kept signed.
      for (int k = 0; k < 3; k++) begin
        if (ok) begin
          pa[k] <= u[(k + 1) % 3] * v[(k + 2) % 3];
          pb[k] <= u[(k + 2) % 3] * v[(k + 1) % 3];
        end else begin
          pa[k] <= '0;
          pb[k] <= '0;
        end
      end
      // Axis.
      for (int k = 0; k < 3; k++) begin
        l[k] <= LW'(pa[k]) - LW'(pb[k]);
      end
      // Projections of every axis and of the center offset.
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          po[i][k] <= PW'($signed(own_box[((1 + i) * 3 + k) * C +: C])) * PW'(l[k]);
          pq[i][k] <= PW'($signed(box[1][((1 + i) * 3 + k) * C +: C])) * PW'(l[k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        pd[k] <= (C + LW + 1)'(d[k]) * (C + LW + 1)'(l[k]);
      end
      // Magnitudes.
      for (int i = 0; i < 3; i++) begin
        mo[i] <= so[i][DW-1] ? DW'(-so[i]) : DW'(so[i]);
        mq[i] <= sq[i][DW-1] ? DW'(-sq[i]) : DW'(sq[i]);
      end
      md <= sd[DDW-1] ? DDW'(-sd) : DDW'(sd);
      // Radii terms and aligned center distance.
      for (int i = 0; i < 3; i++) begin
        ro[i] <= EW'(mo[i]) * EW'(own_box[(12 + i) * C +: C]);
        rq[i] <= EW'(mq[i]) * EW'(box[3][(12 + i) * C +: C]);
      end
      lhs <= LHW'(md) << FRAC_BITS;
    end
  end

  assign flag_out = flg[NS-1];
  assign oth_out  = box[NS-1];

endmodule
